FILE: sv/tli_pkg.sv
// shared constants and types of the table linear interpolator
`timescale 1ns / 1ps

package tli_pkg;

    localparam int ENTRIES_DEFAULT   = 256;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int INDEX_BITS        = 8;
    localparam int CFG_BITS          = 9;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic query;
        logic write;
    } ctl_t;

endpackage

FILE: sv/table_linear_interpolator.sv
// top level of the table linear interpolator
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  s_        | tvalid / tready    | tuser: cmd; tdata: index, position, value, query
//  m_        | tvalid / tready    | tdata: interpolated value
//  cfg_      | we (no wait)       | wdata: entries in use
//
// one item enters per cycle while the pipeline is not held; a query result passes through
// the search levels and the one-bit-per-stage divider
// the whole pipeline holds while the output register is full and not taken
// reset clears valid bits and sets entries in use to 256; table contents are not cleared
`timescale 1ns / 1ps

module table_linear_interpolator #(
    parameter int ENTRIES   = tli_pkg::ENTRIES_DEFAULT,
    parameter int WORD_BITS = tli_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tli_pkg::CFG_BITS-1:0]        cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // index, entry position, entry value, query position
    input  logic [((tli_pkg::INDEX_BITS + 3 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // interpolated value
    output logic [((WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int W      = WORD_BITS;
    localparam int IB     = tli_pkg::INDEX_BITS;
    localparam int MD_W   = ((W + 7) / 8) * 8;
    localparam int AW     = $clog2(ENTRIES);
    localparam int CW     = AW + 1;
    localparam int LEVELS = (ENTRIES > 2) ? $clog2(ENTRIES - 1) : 1;
    localparam int SIDE_W = 2 * W + 1;
    localparam int DSIDE  = W + 1;

    logic                          adv;
    logic [tli_pkg::CFG_BITS-1:0]  entries_in_use_reg;
    logic [CW-1:0]                 n_eff;
    logic [AW-1:0]                 last;

    logic [IB-1:0]                 in_idx;
    logic [W-1:0]                  in_epos;
    logic [W-1:0]                  in_eval;
    logic [W-1:0]                  in_q;
    logic                          in_ok;
    tli_pkg::ctl_t                 in_ctl;

    logic [W-1:0]                  clamp_pos_mem [ENTRIES];
    logic [W-1:0]                  clamp_val_mem [ENTRIES];

    tli_pkg::ctl_t                 a_ctl_reg;
    logic [AW-1:0]                 a_addr_reg;
    logic [W-1:0]                  a_epos_reg;
    logic [W-1:0]                  a_eval_reg;
    logic [W-1:0]                  a_q_reg;
    logic [AW-1:0]                 a_last_reg;
    logic [W-1:0]                  a_p0_reg;
    logic [W-1:0]                  a_pl_reg;
    logic [W-1:0]                  a_v0_reg;
    logic [W-1:0]                  a_vl_reg;
    logic                          a_below;
    logic                          a_clamp;
    logic [W-1:0]                  a_cval;

    tli_pkg::ctl_t                 lv_ctl  [LEVELS+1];
    logic [AW-1:0]                 lv_addr [LEVELS+1];
    logic [W-1:0]                  lv_epos [LEVELS+1];
    logic [W-1:0]                  lv_q    [LEVELS+1];
    logic [AW-1:0]                 lv_lo   [LEVELS+1];
    logic [AW-1:0]                 lv_hi   [LEVELS+1];
    logic [SIDE_W-1:0]             lv_side [LEVELS+1];

    logic [W-1:0]                  brk_pos_mem [ENTRIES];
    logic [W-1:0]                  brk_val_mem [ENTRIES];
    tli_pkg::ctl_t                 b_ctl;
    logic [SIDE_W-1:0]             b_side;

    logic                          c_valid_reg;
    logic [W-1:0]                  c_q_reg;
    logic [W-1:0]                  c_p1_reg;
    logic [W-1:0]                  c_p2_reg;
    logic [W-1:0]                  c_v1_reg;
    logic [W-1:0]                  c_v2_reg;
    logic                          c_clamp_reg;
    logic [W-1:0]                  c_cval_reg;

    logic                          c_desc;
    logic [W-1:0]                  c_span;
    logic [W-1:0]                  c_off;
    logic                          c_dir;
    logic [W-1:0]                  c_mag;
    logic                          c_zero;

    logic                          d_valid_reg;
    logic [W-1:0]                  d_mag_reg;
    logic [W-1:0]                  d_off_reg;
    logic [W-1:0]                  d_span_reg;
    logic [W-1:0]                  d_base_reg;
    logic                          d_dir_reg;

    logic                          e_valid_reg;
    logic [2*W-1:0]                e_prod_reg;
    logic [W-1:0]                  e_span_reg;
    logic [DSIDE-1:0]              e_side_reg;

    logic                          div_valid;
    logic [W-1:0]                  div_quo;
    logic [DSIDE-1:0]              div_side;
    logic [W-1:0]                  div_base;
    logic                          div_dir;
    logic [W-1:0]                  result;

    logic                          m_tvalid_reg;
    logic [W-1:0]                  m_value_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= tli_pkg::CFG_RESET;
        end else if (cfg_we) begin
            entries_in_use_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (entries_in_use_reg < tli_pkg::CFG_BITS'(2)) begin
            n_eff = CW'(2);
        end else if (int'(entries_in_use_reg) > ENTRIES) begin
            n_eff = CW'(ENTRIES);
        end else begin
            n_eff = CW'(entries_in_use_reg);
        end
        last = AW'(n_eff - CW'(1));
    end

    // input unpack
    assign in_idx  = s_tdata[IB-1:0];
    assign in_epos = s_tdata[IB +: W];
    assign in_eval = s_tdata[IB + W +: W];
    assign in_q    = s_tdata[IB + 2 * W +: W];
    assign in_ok   = int'(in_idx) < ENTRIES;

    always_comb begin
        in_ctl.valid = s_tvalid;
        in_ctl.query = s_tvalid && (s_tuser == tli_pkg::CMD_QUERY);
        in_ctl.write = s_tvalid && (s_tuser == tli_pkg::CMD_WRITE) && in_ok;
    end

    // end points of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg <= '0;
        end else if (adv) begin
            a_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_p0_reg   <= clamp_pos_mem[0];
            a_pl_reg   <= clamp_pos_mem[last];
            a_v0_reg   <= clamp_val_mem[0];
            a_vl_reg   <= clamp_val_mem[last];
            a_addr_reg <= AW'(in_idx);
            a_epos_reg <= in_epos;
            a_eval_reg <= in_eval;
            a_q_reg    <= in_q;
            a_last_reg <= last;
            if (in_ctl.write) begin
                clamp_pos_mem[AW'(in_idx)] <= in_epos;
                clamp_val_mem[AW'(in_idx)] <= in_eval;
            end
        end
    end

    always_comb begin
        a_below = a_q_reg <= a_p0_reg;
        a_clamp = a_below || (a_q_reg >= a_pl_reg);
        a_cval  = a_below ? a_v0_reg : a_vl_reg;
    end

    // binary search
    assign lv_ctl[0]  = a_ctl_reg;
    assign lv_addr[0] = a_addr_reg;
    assign lv_epos[0] = a_epos_reg;
    assign lv_q[0]    = a_q_reg;
    assign lv_lo[0]   = '0;
    assign lv_hi[0]   = a_last_reg;
    assign lv_side[0] = {a_clamp, a_cval, a_eval_reg};

    for (genvar k = 0; k < LEVELS; k++) begin : g_level
        tli_search_level #(
            .ENTRIES (ENTRIES),
            .W       (W),
            .AW      (AW),
            .SIDE_W  (SIDE_W)
        ) u_level (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_ctl   (lv_ctl[k]),
            .in_addr  (lv_addr[k]),
            .in_epos  (lv_epos[k]),
            .in_q     (lv_q[k]),
            .in_lo    (lv_lo[k]),
            .in_hi    (lv_hi[k]),
            .in_side  (lv_side[k]),
            .out_ctl  (lv_ctl[k+1]),
            .out_addr (lv_addr[k+1]),
            .out_epos (lv_epos[k+1]),
            .out_q    (lv_q[k+1]),
            .out_lo   (lv_lo[k+1]),
            .out_hi   (lv_hi[k+1]),
            .out_side (lv_side[k+1])
        );
    end

    // bracketing pair
    assign b_ctl  = lv_ctl[LEVELS];
    assign b_side = lv_side[LEVELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_ctl.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_p1_reg    <= brk_pos_mem[lv_lo[LEVELS]];
            c_p2_reg    <= brk_pos_mem[lv_hi[LEVELS]];
            c_v1_reg    <= brk_val_mem[lv_lo[LEVELS]];
            c_v2_reg    <= brk_val_mem[lv_hi[LEVELS]];
            c_q_reg     <= lv_q[LEVELS];
            c_clamp_reg <= b_side[2*W];
            c_cval_reg  <= b_side[2*W-1:W];
            if (b_ctl.write) begin
                brk_pos_mem[lv_addr[LEVELS]] <= lv_epos[LEVELS];
                brk_val_mem[lv_addr[LEVELS]] <= b_side[W-1:0];
            end
        end
    end

    // operand setup
    always_comb begin
        c_desc = c_p2_reg <= c_p1_reg;
        c_span = c_p2_reg - c_p1_reg;
        c_off  = (c_q_reg > c_p1_reg) ? (c_q_reg - c_p1_reg) : '0;
        if (c_off > c_span) begin
            c_off = c_span;
        end
        c_dir  = c_v2_reg >= c_v1_reg;
        c_mag  = c_dir ? (c_v2_reg - c_v1_reg) : (c_v1_reg - c_v2_reg);
        c_zero = c_clamp_reg || c_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_mag_reg  <= c_zero ? '0 : c_mag;
            d_off_reg  <= c_off;
            d_span_reg <= c_zero ? W'(1) : c_span;
            d_base_reg <= c_clamp_reg ? c_cval_reg : c_v1_reg;
            d_dir_reg  <= c_dir;
        end
    end

    // product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_prod_reg <= (2*W)'(d_mag_reg) * (2*W)'(d_off_reg);
            e_span_reg <= d_span_reg;
            e_side_reg <= {d_dir_reg, d_base_reg};
        end
    end

    tli_divider #(
        .W      (W),
        .SIDE_W (DSIDE)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .in_prod   (e_prod_reg),
        .in_span   (e_span_reg),
        .in_side   (e_side_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    assign div_base = div_side[W-1:0];
    assign div_dir  = div_side[W];
    assign result   = div_dir ? (div_base + div_quo) : (div_base - div_quo);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_value_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MD_W'(m_value_reg);

endmodule

FILE: sv/tli_search_level.sv
// one binary search level with its own copy of the position table
`timescale 1ns / 1ps

module tli_search_level #(
    parameter int ENTRIES = tli_pkg::ENTRIES_DEFAULT,
    parameter int W       = tli_pkg::WORD_BITS_DEFAULT,
    parameter int AW      = $clog2(ENTRIES),
    parameter int SIDE_W  = 2 * W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tli_pkg::ctl_t     in_ctl,
    input  logic [AW-1:0]     in_addr,
    input  logic [W-1:0]      in_epos,
    input  logic [W-1:0]      in_q,
    input  logic [AW-1:0]     in_lo,
    input  logic [AW-1:0]     in_hi,
    input  logic [SIDE_W-1:0] in_side,
    output tli_pkg::ctl_t     out_ctl,
    output logic [AW-1:0]     out_addr,
    output logic [W-1:0]      out_epos,
    output logic [W-1:0]      out_q,
    output logic [AW-1:0]     out_lo,
    output logic [AW-1:0]     out_hi,
    output logic [SIDE_W-1:0] out_side
);

    logic [W-1:0]      pos_mem [ENTRIES];
    logic [AW:0]       sum;
    logic [AW-1:0]     mid;
    logic [AW-1:0]     diff;
    logic              active;

    tli_pkg::ctl_t     ctl_reg;
    logic [AW-1:0]     addr_reg;
    logic [W-1:0]      epos_reg;
    logic [W-1:0]      q_reg;
    logic [AW-1:0]     lo_reg;
    logic [AW-1:0]     hi_reg;
    logic [AW-1:0]     mid_reg;
    logic              active_reg;
    logic [W-1:0]      pm_reg;
    logic [SIDE_W-1:0] side_reg;
    logic              upper;

    always_comb begin
        sum    = {1'b0, in_lo} + {1'b0, in_hi};
        mid    = sum[AW:1];
        diff   = in_hi - in_lo;
        active = diff > AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg     <= pos_mem[mid];
            addr_reg   <= in_addr;
            epos_reg   <= in_epos;
            q_reg      <= in_q;
            lo_reg     <= in_lo;
            hi_reg     <= in_hi;
            mid_reg    <= mid;
            active_reg <= active;
            side_reg   <= in_side;
            if (in_ctl.write) begin
                pos_mem[in_addr] <= in_epos;
            end
        end
    end

    assign upper    = pm_reg > q_reg;
    assign out_ctl  = ctl_reg;
    assign out_addr = addr_reg;
    assign out_epos = epos_reg;
    assign out_q    = q_reg;
    assign out_lo   = (active_reg && !upper) ? mid_reg : lo_reg;
    assign out_hi   = (active_reg && upper) ? mid_reg : hi_reg;
    assign out_side = side_reg;

endmodule

FILE: sv/tli_divider.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module tli_divider #(
    parameter int W      = tli_pkg::WORD_BITS_DEFAULT,
    parameter int SIDE_W = W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*W-1:0]    in_prod,
    input  logic [W-1:0]      in_span,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_s [W+1];
    logic [W-1:0]      rem_s   [W+1];
    logic [W-1:0]      low_s   [W+1];
    logic [W-1:0]      quo_s   [W+1];
    logic [W-1:0]      span_s  [W+1];
    logic [SIDE_W-1:0] side_s  [W+1];

    assign valid_s[0] = in_valid;
    assign rem_s[0]   = in_prod[2*W-1:W];
    assign low_s[0]   = in_prod[W-1:0];
    assign quo_s[0]   = '0;
    assign span_s[0]  = in_span;
    assign side_s[0]  = in_side;

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W:0]        trial;
        logic              ge;
        logic [W:0]        diff;
        logic              valid_reg;
        logic [W-1:0]      rem_reg;
        logic [W-1:0]      low_reg;
        logic [W-1:0]      quo_reg;
        logic [W-1:0]      span_reg;
        logic [SIDE_W-1:0] side_reg;

        always_comb begin
            trial = {rem_s[i], low_s[i][W-1]};
            ge    = trial >= {1'b0, span_s[i]};
            diff  = trial - {1'b0, span_s[i]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= valid_s[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= ge ? diff[W-1:0] : trial[W-1:0];
                low_reg  <= {low_s[i][W-2:0], 1'b0};
                quo_reg  <= {quo_s[i][W-2:0], ge};
                span_reg <= span_s[i];
                side_reg <= side_s[i];
            end
        end

        assign valid_s[i+1] = valid_reg;
        assign rem_s[i+1]   = rem_reg;
        assign low_s[i+1]   = low_reg;
        assign quo_s[i+1]   = quo_reg;
        assign span_s[i+1]  = span_reg;
        assign side_s[i+1]  = side_reg;
    end

    assign out_valid = valid_s[W];
    assign out_quo   = quo_s[W];
    assign out_side  = side_s[W];

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the table linear interpolator
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 45;
    localparam int SDW = ((tli_pkg::INDEX_BITS + 3 * 32 + 7) / 8) * 8;

    typedef struct packed {
        tli_pkg::cmd_t cmd;
        logic [7:0]    index;
        logic [31:0]   position;
        logic [31:0]   value;
        logic [31:0]   query;
    } item_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [tli_pkg::CFG_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;

    table_linear_interpolator DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    item_t pending_items[$];
    logic [31:0] expected_values[$];
    logic [31:0] point_tab[256];
    logic [31:0] value_tab[256];
    int unsigned entries_used = 256;
    int errors = 0;
    int queries_seen = 0;
    int results_seen = 0;
    bit idle_enable = 1;
    int hold_cycles = 0;
    bit send_pause = 0;

    function automatic logic [31:0] interp(logic [31:0] q);
        int unsigned n, lo, hi, mid;
        logic [31:0] p1, p2, v1, v2, span, off, mag, delta;
        logic [63:0] prod;
        n = entries_used < 2 ? 2 : (entries_used > 256 ? 256 : entries_used);
        if (q <= point_tab[0]) return value_tab[0];
        if (q >= point_tab[n-1]) return value_tab[n-1];
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (point_tab[mid] > q) hi = mid;
            else lo = mid;
        end
        p1 = point_tab[lo];
        p2 = point_tab[hi];
        v1 = value_tab[lo];
        v2 = value_tab[hi];
        if (p2 <= p1) return v1;
        span = p2 - p1;
        off = q > p1 ? q - p1 : 0;
        if (off > span) off = span;
        mag = v2 >= v1 ? v2 - v1 : v1 - v2;
        prod = 64'(mag) * 64'(off);
        delta = 32'(prod / 64'(span));
        return v2 >= v1 ? v1 + delta : v1 - delta;
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == tli_pkg::CMD_QUERY) begin
                    expected_values.push_back(interp(s_tdata[72 +: 32]));
                    queries_seen++;
                end else begin
                    point_tab[s_tdata[7:0]] = s_tdata[8 +: 32];
                    value_tab[s_tdata[7:0]] = s_tdata[40 +: 32];
                end
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 0;
                end else if (pending_items.size() > 0 && !send_pause) begin
                    item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= it.cmd;
                    s_tdata <= {it.query, it.value, it.position, it.index};
                    if (idle_enable && $urandom_range(0, 9) == 0)
                        s_gap <= $urandom_range(1, 11);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_values.size() == 0) begin
                    $error("interpolated_value: unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    logic [31:0] want;
                    want = expected_values.pop_front();
                    if (m_tdata !== want) begin
                        $error("interpolated_value: expected %h actual %h", want, m_tdata);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (idle_enable && $urandom_range(0, 9) == 0)
                    m_gap <= $urandom_range(1, 11);
            end
        end
    end

    task automatic add_write(int idx, logic [31:0] p, logic [31:0] v);
        item_t it;
        it = '{tli_pkg::CMD_WRITE, idx[7:0], p, v, $urandom()};
        pending_items.push_back(it);
    endtask

    task automatic add_query(logic [31:0] q);
        item_t it;
        it = '{tli_pkg::CMD_QUERY, 8'($urandom()), $urandom(), $urandom(), q};
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_values.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_entries(int unsigned n);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= n[tli_pkg::CFG_BITS-1:0];
        entries_used = n;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // ascending table over the slots in use, with random steps and some equal neighbors
    task automatic fill_table(int unsigned n, logic [31:0] start, int unsigned step_max);
        logic [31:0] p;
        p = start;
        for (int i = 0; i < n; i++) begin
            add_write(i, p, $urandom());
            if ($urandom_range(0, 7) != 0) p = p + $urandom_range(1, step_max);
        end
    endtask

    task automatic random_queries(int count, logic [31:0] lo_q, logic [31:0] hi_q);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) add_query($urandom());
            else add_query(lo_q + 32'($urandom_range(0, hi_q - lo_q)));
        end
    endtask

    initial begin
        int unsigned sizes[5];
        sizes = '{2, 256, 3, 17, 100};
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, equal points, descending values, clamps
        for (int i = 0; i < 256; i++) add_write(i, 32'(i) << 8, 32'hFFFF_FFFF - (32'(i) << 16));
        add_write(1, 32'h0000_0100, 32'h0000_0000);
        add_write(2, 32'h0000_0100, 32'h1234_5678);
        add_write(255, 32'hFFFF_FFFF, 32'h0000_0000);
        add_query(32'h0);
        add_query(32'hFFFF_FFFF);
        add_query(32'h0000_0080);
        add_query(32'h0000_0100);
        add_query(32'h0000_0180);
        add_query(32'h0000_FE80);
        add_query(32'h8000_0000);
        add_query(32'h0000_0301);
        drain();

        // long receiver stall while items keep coming
        random_queries(30, 0, 32'h0001_0000);
        hold_cycles = 300;
        drain();

        foreach (sizes[k]) begin
            set_entries(sizes[k]);
            fill_table(sizes[k], $urandom_range(0, 32'h1000_0000),
                       k == 1 ? 32'h0010_0000 : 32'h0100_0000);
            random_queries(75, 0, 32'hFFFF_FFFF >> (k == 1 ? 0 : 2));
            if (k == 4) idle_enable = 0;
            if (k != 4) begin
                // sender pauses until every outstanding result is back
                repeat (40) @(posedge aclk);
                send_pause = 1;
                while (expected_values.size() > 0 || s_tvalid) @(posedge aclk);
                send_pause = 0;
            end
            drain();
        end

        $display("covered %0d queries over table sizes 2..256, clamps, equal points, stalls",
                 queries_seen);
        $display("results checked: %0d", results_seen);
        if (errors == 0 && expected_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
sv/tli_pkg.sv
sv/tli_search_level.sv
sv/tli_divider.sv
sv/table_linear_interpolator.sv
dv/tb_top.sv
